### hdl/nlcp_pkg.sv
// ----------------------------------------------------------------------------
// nlcp_pkg
// Shared constants, types, microcode table and CRC step for the NMEA line
// packetizer.
// ----------------------------------------------------------------------------
package nlcp_pkg;

  localparam int LINE_BYTES = 100;
  localparam int LEN_W      = $clog2(LINE_BYTES + 1);
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int MIN_KEEP   = 5;

  localparam logic [7:0]  SYNC_A     = 8'hAA;
  localparam logic [7:0]  SYNC_B     = 8'h56;
  localparam logic [7:0]  START_MARK = 8'h24;
  localparam logic [7:0]  CHAR_CR    = 8'd13;
  localparam logic [7:0]  CHAR_LF    = 8'd10;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  // Microprogram step addresses
  localparam pc_t STEP_IDLE   = PC_W'(0);
  localparam pc_t STEP_SYNC_A = PC_W'(1);
  localparam pc_t STEP_SYNC_B = PC_W'(2);
  localparam pc_t STEP_LEN    = PC_W'(3);
  localparam pc_t STEP_RD     = PC_W'(4);
  localparam pc_t STEP_DATA   = PC_W'(5);
  localparam pc_t STEP_CRC_LO = PC_W'(6);
  localparam pc_t STEP_CRC_HI = PC_W'(7);

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_SYNC_A,
    EMIT_SYNC_B,
    EMIT_LEN,
    EMIT_MEM,
    EMIT_CRC_LO,
    EMIT_CRC_HI
  } emit_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_GOOD_TERM,
    COND_MORE_DATA
  } cond_t;

  typedef struct packed {
    logic  take_in;
    emit_t emit;
    logic  crc_init;
    logic  crc_feed;
    logic  idx_clr;
    logic  idx_inc;
    logic  last;
    cond_t cond;
    pc_t   jmp_tgt;
    pc_t   seq_tgt;
  } uword_t;

  typedef struct packed {
    logic good_term;
    logic more_data;
  } dp_stat_t;

  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    w.take_in  = 1'b0;
    w.emit     = EMIT_NONE;
    w.crc_init = 1'b0;
    w.crc_feed = 1'b0;
    w.idx_clr  = 1'b0;
    w.idx_inc  = 1'b0;
    w.last     = 1'b0;
    w.cond     = COND_NEVER;
    w.jmp_tgt  = STEP_IDLE;
    w.seq_tgt  = STEP_IDLE;
    case (pc)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = COND_GOOD_TERM;
        w.jmp_tgt = STEP_SYNC_A;
        w.seq_tgt = STEP_IDLE;
      end
      STEP_SYNC_A: begin
        w.emit     = EMIT_SYNC_A;
        w.crc_init = 1'b1;
        w.seq_tgt  = STEP_SYNC_B;
      end
      STEP_SYNC_B: begin
        w.emit    = EMIT_SYNC_B;
        w.seq_tgt = STEP_LEN;
      end
      STEP_LEN: begin
        w.emit     = EMIT_LEN;
        w.crc_feed = 1'b1;
        w.idx_clr  = 1'b1;
        w.seq_tgt  = STEP_RD;
      end
      STEP_RD: begin
        w.seq_tgt = STEP_DATA;
      end
      STEP_DATA: begin
        w.emit     = EMIT_MEM;
        w.crc_feed = 1'b1;
        w.idx_inc  = 1'b1;
        w.cond     = COND_MORE_DATA;
        w.jmp_tgt  = STEP_RD;
        w.seq_tgt  = STEP_CRC_LO;
      end
      STEP_CRC_LO: begin
        w.emit    = EMIT_CRC_LO;
        w.seq_tgt = STEP_CRC_HI;
      end
      STEP_CRC_HI: begin
        w.emit    = EMIT_CRC_HI;
        w.last    = 1'b1;
        w.seq_tgt = STEP_IDLE;
      end
      default: begin
        w.seq_tgt = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // One byte through CRC16-CCITT, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### hdl/nmea_line_crc_packetizer.sv
// ----------------------------------------------------------------------------
// nmea_line_crc_packetizer
// Collects received serial bytes into lines and sends each valid NMEA line
// as a sync-framed packet with length and CRC16-CCITT trailer.
// ----------------------------------------------------------------------------
// Each input item is one received byte. Any byte other than CR or LF is
// appended to the 100-byte line store at its current end; a data byte that
// arrives with the store full empties the line and is dropped. On CR or LF a
// line of more than five bytes that begins with '$' leaves as a packet:
// AA 56, length byte, payload, then the CRC16-CCITT (init FFFF, poly 1021)
// over length and payload, low byte first. Packet bytes travel two per result
// item, the last item flagged by out_packet_end and, for an odd packet size,
// carrying a single byte with out_second_valid low. Data bytes and rejected
// terminators are taken on the idle step, and the microprogram stays there.
// A packet terminator starts the walk: the microprogram spends two steps per
// payload byte (address the line store, then take its registered read data),
// so the line store's single read port sets the pace. in_stall stays high
// while a packet is being walked; a finished result may still wait in the
// output register while new bytes are accepted.
// ----------------------------------------------------------------------------
module nmea_line_crc_packetizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_first_byte,
  output logic [7:0] out_second_byte,
  output logic       out_second_valid,
  output logic       out_packet_end
);

  nlcp_pkg::uword_t   uw;
  nlcp_pkg::dp_stat_t stat;
  logic               go;
  logic               pack_ready;
  logic               push;
  logic [7:0]         emit_byte;

  // accept input bytes only on the idle step of the microprogram
  assign in_stall = !uw.take_in;

  // hand a byte to the packer whenever an emitting step advances
  assign push = go && (uw.emit != nlcp_pkg::EMIT_NONE);

  nlcp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .pack_ready (pack_ready),
    .stat       (stat),
    .uw         (uw),
    .go         (go)
  );

  nlcp_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .uw         (uw),
    .go         (go),
    .in_rx_byte (in_rx_byte),
    .stat       (stat),
    .emit_byte  (emit_byte)
  );

  nlcp_packer u_pack (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .push_last        (uw.last),
    .push_byte        (emit_byte),
    .ready            (pack_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_byte   (out_first_byte),
    .out_second_byte  (out_second_byte),
    .out_second_valid (out_second_valid),
    .out_packet_end   (out_packet_end)
  );

endmodule

### hdl/nlcp_seq.sv
// ----------------------------------------------------------------------------
// nlcp_seq
// Step counter and microcode lookup; resolves waits and conditional jumps.
// ----------------------------------------------------------------------------
module nlcp_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               pack_ready,
  input  nlcp_pkg::dp_stat_t stat,
  output nlcp_pkg::uword_t   uw,
  output logic               go
);

  nlcp_pkg::pc_t pc_r;
  nlcp_pkg::pc_t pc_nxt;
  logic          cond_hit;

  assign uw = nlcp_pkg::ucode_rom(pc_r);

  // hold the step until its input or output side can move
  always_comb begin
    if (uw.take_in) begin
      go = in_valid;
    end else if (uw.emit != nlcp_pkg::EMIT_NONE) begin
      go = pack_ready;
    end else begin
      go = 1'b1;
    end
  end

  always_comb begin
    case (uw.cond)
      nlcp_pkg::COND_GOOD_TERM: cond_hit = stat.good_term;
      nlcp_pkg::COND_MORE_DATA: cond_hit = stat.more_data;
      default:                  cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      pc_nxt = cond_hit ? uw.jmp_tgt : uw.seq_tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= nlcp_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### hdl/nlcp_datapath.sv
// ----------------------------------------------------------------------------
// nlcp_datapath
// Line store, line length, read index, CRC register and packet byte select.
// ----------------------------------------------------------------------------
module nlcp_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  nlcp_pkg::uword_t   uw,
  input  logic               go,
  input  logic [7:0]         in_rx_byte,
  output nlcp_pkg::dp_stat_t stat,
  output logic [7:0]         emit_byte
);

  logic [7:0]                  line_mem [nlcp_pkg::LINE_BYTES];
  logic [nlcp_pkg::LEN_W-1:0]  line_len_r;
  logic [nlcp_pkg::LEN_W-1:0]  line_len_nxt;
  logic [nlcp_pkg::LEN_W-1:0]  pkt_len_r;
  logic [nlcp_pkg::ADDR_W-1:0] idx_r;
  logic [7:0]                  first_r;
  logic [7:0]                  rd_data_r;
  logic [15:0]                 crc_r;
  logic                        fire;
  logic                        is_term;
  logic                        has_room;
  logic [nlcp_pkg::LEN_W:0]    idx_p1;

  assign fire     = go && uw.take_in;
  assign is_term  = (in_rx_byte == nlcp_pkg::CHAR_CR) || (in_rx_byte == nlcp_pkg::CHAR_LF);
  assign has_room = line_len_r < nlcp_pkg::LEN_W'(nlcp_pkg::LINE_BYTES);
  assign idx_p1   = (nlcp_pkg::LEN_W+1)'(idx_r) + 1'b1;

  assign stat.good_term = is_term
                       && (line_len_r > nlcp_pkg::LEN_W'(nlcp_pkg::MIN_KEEP))
                       && (first_r == nlcp_pkg::START_MARK);
  assign stat.more_data = idx_p1 < (nlcp_pkg::LEN_W+1)'(pkt_len_r);

  always_comb begin
    case (uw.emit)
      nlcp_pkg::EMIT_SYNC_A: emit_byte = nlcp_pkg::SYNC_A;
      nlcp_pkg::EMIT_SYNC_B: emit_byte = nlcp_pkg::SYNC_B;
      nlcp_pkg::EMIT_LEN:    emit_byte = 8'(pkt_len_r);
      nlcp_pkg::EMIT_MEM:    emit_byte = rd_data_r;
      nlcp_pkg::EMIT_CRC_LO: emit_byte = crc_r[7:0];
      nlcp_pkg::EMIT_CRC_HI: emit_byte = crc_r[15:8];
      default:               emit_byte = 8'h00;
    endcase
  end

  always_comb begin
    line_len_nxt = line_len_r;
    if (fire) begin
      if (is_term || !has_room) begin
        line_len_nxt = '0;
      end else begin
        line_len_nxt = line_len_r + 1'b1;
      end
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (fire && !is_term && has_room) begin
      line_mem[line_len_r[nlcp_pkg::ADDR_W-1:0]] <= in_rx_byte;
    end
    rd_data_r <= line_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (fire && !is_term && (line_len_r == '0)) begin
      first_r <= in_rx_byte;
    end
    if (fire && is_term) begin
      pkt_len_r <= line_len_r;
    end
    if (go && uw.crc_init) begin
      crc_r <= nlcp_pkg::CRC_INIT;
    end else if (go && uw.crc_feed) begin
      crc_r <= nlcp_pkg::crc_feed(crc_r, emit_byte);
    end
    if (go && uw.idx_clr) begin
      idx_r <= '0;
    end else if (go && uw.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
    end else begin
      line_len_r <= line_len_nxt;
    end
  end

endmodule

### hdl/nlcp_packer.sv
// ----------------------------------------------------------------------------
// nlcp_packer
// Pairs packet bytes into result items and holds them in the output register.
// ----------------------------------------------------------------------------
module nlcp_packer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       push_last,
  input  logic [7:0] push_byte,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_first_byte,
  output logic [7:0] out_second_byte,
  output logic       out_second_valid,
  output logic       out_packet_end
);

  logic       half_v_r;
  logic       half_v_nxt;
  logic [7:0] half_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] first_r;
  logic [7:0] second_r;
  logic       second_v_r;
  logic       end_r;
  logic       out_free;
  logic       load_out;

  assign out_free = !out_valid_r || !out_stall;
  assign ready    = (half_v_r || push_last) ? out_free : 1'b1;
  assign load_out = push && (half_v_r || push_last);

  always_comb begin
    half_v_nxt = half_v_r;
    if (push) begin
      half_v_nxt = !half_v_r && !push_last;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !half_v_r && !push_last) begin
      half_r <= push_byte;
    end
    if (load_out) begin
      if (half_v_r) begin
        first_r    <= half_r;
        second_r   <= push_byte;
        second_v_r <= 1'b1;
      end else begin
        first_r    <= push_byte;
        second_r   <= 8'h00;
        second_v_r <= 1'b0;
      end
      end_r <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      half_v_r    <= half_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_byte   = first_r;
  assign out_second_byte  = second_r;
  assign out_second_valid = second_v_r;
  assign out_packet_end   = end_r;

endmodule

### hdl/nlcp_checker.sv
// ----------------------------------------------------------------------------
// nlcp_checker
// Port-level checks on the packetizer's result stream.
// ----------------------------------------------------------------------------
module nlcp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_first_byte,
  input logic [7:0] out_second_byte,
  input logic       out_second_valid,
  input logic       out_packet_end
);

  // a single-byte result can only close a packet
  a_single_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_second_valid) |-> (out_packet_end && (out_second_byte == 8'h00)))
    else $error("single-byte result without packet end");

  // mid-packet results are taken only while the input side is held off
  a_mid_packet_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_packet_end) |-> in_stall)
    else $error("input accepted while packet still in flight");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_first_byte)
      && $stable(out_second_byte) && $stable(out_second_valid) && $stable(out_packet_end)))
    else $error("stalled result changed");

  // a held-off input item keeps its byte until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_rx_byte)))
    else $error("stalled input item changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nmea_line_crc_packetizer nlcp_checker u_nlcp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_rx_byte       (in_rx_byte),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_first_byte   (out_first_byte),
  .out_second_byte  (out_second_byte),
  .out_second_valid (out_second_valid),
  .out_packet_end   (out_packet_end)
);
